@@ rtl/mesh_chunk_stream_parser_defines.svh @@
// Assertion macros used by the checker file of the chunk stream parser.
`ifndef MESH_CHUNK_STREAM_PARSER_DEFINES_SVH
`define MESH_CHUNK_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk of the module that uses it.
`define MCSP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("mcsp check failed");

// Next-cycle implication, sampled on i_clk of the module that uses it.
`define MCSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mcsp check failed");

`endif

@@ rtl/mcsp_pkg.sv @@
// Types, constants and helpers of the mesh chunk stream parser.
package mcsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] item_index;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_NAME   = 4'd1,
        PH_VCOUNT = 4'd2,
        PH_VERTEX = 4'd3,
        PH_FCOUNT = 4'd4,
        PH_FACE   = 4'd5,
        PH_MCOUNT = 4'd6,
        PH_MAP    = 4'd7,
        PH_SKIP   = 4'd8
    } t_phase;

    localparam logic [2:0] KIND_NAME   = 3'd0;
    localparam logic [2:0] KIND_VCOUNT = 3'd1;
    localparam logic [2:0] KIND_VERTEX = 3'd2;
    localparam logic [2:0] KIND_FCOUNT = 3'd3;
    localparam logic [2:0] KIND_FACE   = 3'd4;
    localparam logic [2:0] KIND_MAP    = 3'd5;
    localparam logic [2:0] KIND_SHORT  = 3'd6;

    localparam logic [15:0] ID_MAIN     = 16'h4d4d;
    localparam logic [15:0] ID_EDIT     = 16'h3d3d;
    localparam logic [15:0] ID_OBJECT   = 16'h4000;
    localparam logic [15:0] ID_TRIMESH  = 16'h4100;
    localparam logic [15:0] ID_VERTICES = 16'h4110;
    localparam logic [15:0] ID_FACES    = 16'h4120;
    localparam logic [15:0] ID_MAPPING  = 16'h4140;

    localparam logic [31:0] HDR_LEN    = 32'd6;
    localparam logic [4:0]  NAME_LIMIT = 5'd20;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          QUEUE_AW    = 2;

    function automatic t_out_item make_rec(input logic [2:0]  kind,
                                           input logic [15:0] idx,
                                           input logic [31:0] a,
                                           input logic [31:0] b,
                                           input logic [31:0] c);
        t_out_item r;
        r.record_kind = kind;
        r.item_index  = idx;
        r.word_a      = a;
        r.word_b      = b;
        r.word_c      = c;
        return r;
    endfunction

endpackage

@@ rtl/mcsp_front.sv @@
// Front end: per-byte chunk parser that classifies bytes and builds records.
module mcsp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  mcsp_pkg::t_in_item i_item,
    output logic               o_rec_valid,
    output mcsp_pkg::t_out_item o_rec
);

    mcsp_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [7:0]  r_hdr [5];
    logic [7:0]  n_hdr [5];
    logic [7:0]  cur_hdr [5];
    logic [3:0]  r_bc, n_bc, cur_bc;
    logic [31:0] r_acc [3];
    logic [31:0] n_acc [3];
    logic [31:0] acc_wr [3];
    logic [15:0] r_lcount, n_lcount;
    logic [15:0] r_lpos, n_lpos;
    logic [31:0] r_skip, n_skip;
    logic [4:0]  r_nlen, n_nlen;

    logic [7:0]  byte_in;
    logic        acc_we;
    logic [1:0]  acc_w;
    logic [1:0]  acc_s;
    logic [15:0] hdr_id;
    logic [31:0] hdr_len;
    logic [15:0] lpos_inc;
    logic [4:0]  nlen_inc;

    assign byte_in  = i_item.data_byte;
    assign hdr_id   = {cur_hdr[1], cur_hdr[0]};
    assign hdr_len  = {byte_in, cur_hdr[4], cur_hdr[3], cur_hdr[2]};
    assign lpos_inc = r_lpos + 16'd1;
    assign nlen_inc = r_nlen + 5'd1;

    // Restart discards header and record progress before the byte is used.
    always_comb begin
        if (i_item.file_start) begin
            cur_phase = mcsp_pkg::PH_HEADER;
            cur_bc    = 4'd0;
            for (int k = 0; k < 5; k++) begin
                cur_hdr[k] = 8'd0;
            end
        end else begin
            cur_phase = r_phase;
            cur_bc    = r_bc;
            for (int k = 0; k < 5; k++) begin
                cur_hdr[k] = r_hdr[k];
            end
        end
    end

    // Byte lane of the word accumulators; faces use 16-bit words.
    always_comb begin
        acc_we = 1'b0;
        acc_w  = cur_bc[3:2];
        acc_s  = cur_bc[1:0];
        case (cur_phase)
            mcsp_pkg::PH_VCOUNT, mcsp_pkg::PH_FCOUNT, mcsp_pkg::PH_MCOUNT,
            mcsp_pkg::PH_VERTEX, mcsp_pkg::PH_MAP: begin
                acc_we = 1'b1;
            end
            mcsp_pkg::PH_FACE: begin
                acc_we = (cur_bc < 4'd6);
                acc_w  = cur_bc[2:1];
                acc_s  = {1'b0, cur_bc[0]};
            end
            default: begin
                acc_we = 1'b0;
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            acc_wr[k] = i_item.file_start ? 32'd0 : r_acc[k];
            if (acc_we && (acc_w == 2'(k))) begin
                acc_wr[k][8*acc_s +: 8] = byte_in;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_bc        = r_bc;
        n_lcount    = r_lcount;
        n_lpos      = r_lpos;
        n_skip      = r_skip;
        n_nlen      = r_nlen;
        o_rec_valid = 1'b0;
        o_rec       = '0;
        for (int k = 0; k < 5; k++) begin
            n_hdr[k] = r_hdr[k];
        end
        for (int k = 0; k < 3; k++) begin
            n_acc[k] = r_acc[k];
        end
        if (i_en) begin
            n_phase = cur_phase;
            n_bc    = cur_bc;
            for (int k = 0; k < 5; k++) begin
                n_hdr[k] = cur_hdr[k];
            end
            for (int k = 0; k < 3; k++) begin
                n_acc[k] = acc_wr[k];
            end
            case (cur_phase)
                mcsp_pkg::PH_HEADER: begin
                    if (cur_bc >= 4'd5) begin
                        n_bc = 4'd0;
                        for (int k = 0; k < 5; k++) begin
                            n_hdr[k] = 8'd0;
                        end
                        for (int k = 0; k < 3; k++) begin
                            n_acc[k] = 32'd0;
                        end
                        if (hdr_id == mcsp_pkg::ID_MAIN || hdr_id == mcsp_pkg::ID_EDIT ||
                            hdr_id == mcsp_pkg::ID_TRIMESH) begin
                            n_phase = mcsp_pkg::PH_HEADER;
                        end else if (hdr_id == mcsp_pkg::ID_OBJECT) begin
                            n_nlen  = 5'd0;
                            n_phase = mcsp_pkg::PH_NAME;
                        end else if (hdr_id == mcsp_pkg::ID_VERTICES) begin
                            n_phase = mcsp_pkg::PH_VCOUNT;
                        end else if (hdr_id == mcsp_pkg::ID_FACES) begin
                            n_phase = mcsp_pkg::PH_FCOUNT;
                        end else if (hdr_id == mcsp_pkg::ID_MAPPING) begin
                            n_phase = mcsp_pkg::PH_MCOUNT;
                        end else if (hdr_len < mcsp_pkg::HDR_LEN) begin
                            o_rec_valid = 1'b1;
                            o_rec = mcsp_pkg::make_rec(mcsp_pkg::KIND_SHORT, 16'd0,
                                                       hdr_len, {16'd0, hdr_id}, 32'd0);
                            n_phase = mcsp_pkg::PH_HEADER;
                        end else if (hdr_len == mcsp_pkg::HDR_LEN) begin
                            n_phase = mcsp_pkg::PH_HEADER;
                        end else begin
                            n_skip  = hdr_len - mcsp_pkg::HDR_LEN;
                            n_phase = mcsp_pkg::PH_SKIP;
                        end
                    end else begin
                        n_hdr[cur_bc[2:0]] = byte_in;
                        n_bc = cur_bc + 4'd1;
                    end
                end
                mcsp_pkg::PH_NAME: begin
                    o_rec_valid = 1'b1;
                    o_rec = mcsp_pkg::make_rec(mcsp_pkg::KIND_NAME, {11'd0, r_nlen},
                                               {24'd0, byte_in}, 32'd0, 32'd0);
                    n_nlen = nlen_inc;
                    if (byte_in == 8'd0 || nlen_inc >= mcsp_pkg::NAME_LIMIT) begin
                        n_nlen  = 5'd0;
                        n_bc    = 4'd0;
                        n_phase = mcsp_pkg::PH_HEADER;
                        for (int k = 0; k < 3; k++) begin
                            n_acc[k] = 32'd0;
                        end
                    end
                end
                mcsp_pkg::PH_VCOUNT, mcsp_pkg::PH_FCOUNT, mcsp_pkg::PH_MCOUNT: begin
                    n_bc = cur_bc + 4'd1;
                    if (cur_bc >= 4'd1) begin
                        if (cur_phase == mcsp_pkg::PH_VCOUNT) begin
                            o_rec_valid = 1'b1;
                            o_rec = mcsp_pkg::make_rec(mcsp_pkg::KIND_VCOUNT, 16'd0,
                                                       {16'd0, acc_wr[0][15:0]}, 32'd0, 32'd0);
                            n_phase = mcsp_pkg::PH_VERTEX;
                        end else if (cur_phase == mcsp_pkg::PH_FCOUNT) begin
                            o_rec_valid = 1'b1;
                            o_rec = mcsp_pkg::make_rec(mcsp_pkg::KIND_FCOUNT, 16'd0,
                                                       {16'd0, acc_wr[0][15:0]}, 32'd0, 32'd0);
                            n_phase = mcsp_pkg::PH_FACE;
                        end else begin
                            n_phase = mcsp_pkg::PH_MAP;
                        end
                        // An empty list goes straight back to header parsing.
                        if (acc_wr[0][15:0] == 16'd0) begin
                            n_phase = mcsp_pkg::PH_HEADER;
                        end
                        n_lcount = acc_wr[0][15:0];
                        n_lpos   = 16'd0;
                        n_bc     = 4'd0;
                        for (int k = 0; k < 3; k++) begin
                            n_acc[k] = 32'd0;
                        end
                    end
                end
                mcsp_pkg::PH_VERTEX, mcsp_pkg::PH_FACE, mcsp_pkg::PH_MAP: begin
                    n_bc = cur_bc + 4'd1;
                    if ((cur_phase == mcsp_pkg::PH_VERTEX && cur_bc >= 4'd11) ||
                        (cur_phase != mcsp_pkg::PH_VERTEX && cur_bc >= 4'd7)) begin
                        o_rec_valid = 1'b1;
                        if (cur_phase == mcsp_pkg::PH_VERTEX) begin
                            o_rec = mcsp_pkg::make_rec(mcsp_pkg::KIND_VERTEX, r_lpos,
                                                       acc_wr[0], acc_wr[1], acc_wr[2]);
                        end else if (cur_phase == mcsp_pkg::PH_FACE) begin
                            o_rec = mcsp_pkg::make_rec(mcsp_pkg::KIND_FACE, r_lpos,
                                                       acc_wr[0], acc_wr[1], acc_wr[2]);
                        end else begin
                            o_rec = mcsp_pkg::make_rec(mcsp_pkg::KIND_MAP, r_lpos,
                                                       acc_wr[0], acc_wr[1], 32'd0);
                        end
                        n_lpos = lpos_inc;
                        n_bc   = 4'd0;
                        for (int k = 0; k < 3; k++) begin
                            n_acc[k] = 32'd0;
                        end
                        if (lpos_inc >= r_lcount) begin
                            n_phase = mcsp_pkg::PH_HEADER;
                        end
                    end
                end
                mcsp_pkg::PH_SKIP: begin
                    if (r_skip != 32'd0) begin
                        n_skip = r_skip - 32'd1;
                    end
                    if (r_skip <= 32'd1) begin
                        n_phase = mcsp_pkg::PH_HEADER;
                    end
                end
                default: begin
                    n_phase = mcsp_pkg::PH_HEADER;
                    n_bc    = 4'd0;
                    for (int k = 0; k < 3; k++) begin
                        n_acc[k] = 32'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mcsp_pkg::PH_HEADER;
            r_bc     <= 4'd0;
            r_lcount <= 16'd0;
            r_lpos   <= 16'd0;
            r_skip   <= 32'd0;
            r_nlen   <= 5'd0;
            for (int k = 0; k < 5; k++) begin
                r_hdr[k] <= 8'd0;
            end
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= 32'd0;
            end
        end else begin
            r_phase  <= n_phase;
            r_bc     <= n_bc;
            r_lcount <= n_lcount;
            r_lpos   <= n_lpos;
            r_skip   <= n_skip;
            r_nlen   <= n_nlen;
            for (int k = 0; k < 5; k++) begin
                r_hdr[k] <= n_hdr[k];
            end
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= n_acc[k];
            end
        end
    end

endmodule

@@ rtl/mcsp_queue.sv @@
// Back end: short record queue that holds finished records for the consumer.
module mcsp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  mcsp_pkg::t_out_item i_wr_data,
    input  logic                i_rd,
    output mcsp_pkg::t_out_item o_rd_data,
    output logic                o_full,
    output logic                o_empty
);

    mcsp_pkg::t_out_item r_slot [mcsp_pkg::QUEUE_DEPTH];
    logic [mcsp_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [mcsp_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [mcsp_pkg::QUEUE_AW:0]   r_count, n_count;
    logic                          do_wr, do_rd;

    assign o_full    = (r_count == (mcsp_pkg::QUEUE_AW+1)'(mcsp_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/mesh_chunk_stream_parser.sv @@
// A record is written into the record queue at the edge that accepts the byte that completes it, and
// is shown on o_result once older records have left. Throughput: one byte per cycle; the parser does
// fixed work per byte in one state update. Bytes stall only when the four-entry record queue is full.
// Reset: synchronous, active low; parser returns to expecting a chunk header, queue empties.
// No clearing pass after reset: bytes are taken in the first cycle after reset is released.
// Top level of the mesh chunk stream parser.
module mesh_chunk_stream_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mcsp_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output mcsp_pkg::t_out_item o_result
);

    // A byte request is taken whenever the record queue has room. Since each
    // byte yields at most one record, room for one entry is all it needs.
    logic                accept;
    logic                rec_valid;
    mcsp_pkg::t_out_item rec;

    assign accept = push && !full;

    // The front end walks the chunk structure: headers, names, counts and
    // lists, and produces a record on the byte that finishes it.
    mcsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_item     (i_item),
        .o_rec_valid(rec_valid),
        .o_rec      (rec)
    );

    // The queue decouples the parser from the consumer. The oldest record is
    // presented on o_result while empty is low and leaves on pop.
    mcsp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept && rec_valid),
        .i_wr_data(rec),
        .i_rd     (pop),
        .o_rd_data(o_result),
        .o_full   (full),
        .o_empty  (empty)
    );

endmodule

@@ rtl/mcsp_checker.sv @@
// Port-level checks of the mesh chunk stream parser, bound to the top level.
`include "mesh_chunk_stream_parser_defines.svh"

module mcsp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input mcsp_pkg::t_out_item o_result
);

    logic name_shown;
    logic name_words_zero;

    assign name_shown      = i_rst_n && !empty &&
                             (o_result.record_kind == mcsp_pkg::KIND_NAME);
    assign name_words_zero = (o_result.word_a[31:8] == 24'd0) &&
                             (o_result.word_b == 32'd0) && (o_result.word_c == 32'd0);

    `MCSP_ASSERT_NEXT(a_reset_empty, !i_rst_n, empty && !full)
    `MCSP_ASSERT_NEXT(a_no_spurious, i_rst_n && empty && !(push && !full), empty)
    `MCSP_ASSERT_NEXT(a_hold_result, i_rst_n && !empty && !pop, !empty && $stable(o_result))
    `MCSP_ASSERT_IMPL(a_full_not_empty, i_rst_n && full, !empty)
    `MCSP_ASSERT_IMPL(a_name_words, name_shown, name_words_zero)

endmodule

bind mesh_chunk_stream_parser mcsp_checker u_mcsp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_result(o_result)
);

@@ bench/tb_mesh_chunk_stream_parser.sv @@
// Self-checking testbench of the mesh chunk stream parser: byte stimulus and record checks.
module tb_mesh_chunk_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import mcsp_pkg::*;

    // The run stops here even if the parser hangs. Even with the longest
    // gaps and stalls a correct run takes far fewer cycles.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 600;
    // After the last record, wait this long to catch any stray records.
    localparam int DRAIN_CYCLES = 20;

    // The scoreboard holds its own copy of the parser state. Every accepted
    // byte is run through that copy, and every record that the byte should
    // produce is queued until the parser hands it out.
    class chunk_record_scoreboard;
        t_phase      phase;
        logic [47:0] hdr;
        int unsigned bcnt;
        logic [31:0] acc [3];
        logic [15:0] lcount;
        logic [15:0] lpos;
        logic [31:0] skip_left;
        logic [4:0]  name_len;
        t_out_item   pending_records[$];
        int          errors;

        function new();
            phase     = PH_HEADER;
            hdr       = '0;
            lcount    = '0;
            lpos      = '0;
            skip_left = '0;
            name_len  = '0;
            errors    = 0;
            clear_record();
        endfunction

        function void clear_record();
            bcnt = 0;
            foreach (acc[i]) acc[i] = '0;
        endfunction

        function void queue_record(logic [2:0] kind, logic [15:0] idx,
                                   logic [31:0] a, logic [31:0] b, logic [31:0] c);
            t_out_item rec;
            rec.record_kind = kind;
            rec.item_index  = idx;
            rec.word_a      = a;
            rec.word_b      = b;
            rec.word_c      = c;
            pending_records.push_back(rec);
        endfunction

        // Little-endian placement of one byte into the word accumulators.
        function void place_byte(logic [7:0] b, int unsigned word_bytes);
            int unsigned w;
            int unsigned s;
            w = bcnt / word_bytes;
            s = (bcnt % word_bytes) * 8;
            if (w < 3) acc[w] |= 32'(b) << s;
        endfunction

        function void open_list(t_phase nxt);
            lcount = acc[0][15:0];
            lpos   = '0;
            clear_record();
            phase  = (lcount == 16'd0) ? PH_HEADER : nxt;
        endfunction

        function void next_record();
            lpos = lpos + 16'd1;
            clear_record();
            if (lpos >= lcount) phase = PH_HEADER;
        endfunction

        function void note_byte(t_in_item it);
            logic [7:0]  b;
            logic [15:0] id;
            logic [31:0] len;
            b = it.data_byte;
            if (it.file_start) begin
                phase = PH_HEADER;
                hdr   = '0;
                clear_record();
            end
            case (phase)
                PH_HEADER: begin
                    hdr  |= 48'(b) << (8 * (bcnt % 6));
                    bcnt += 1;
                    if (bcnt >= 6) begin
                        id    = hdr[15:0];
                        len   = hdr[47:16];
                        hdr   = '0;
                        clear_record();
                        phase = PH_HEADER;
                        case (id)
                            ID_MAIN, ID_EDIT, ID_TRIMESH: phase = PH_HEADER;
                            ID_OBJECT: begin
                                name_len = '0;
                                phase    = PH_NAME;
                            end
                            ID_VERTICES: phase = PH_VCOUNT;
                            ID_FACES:    phase = PH_FCOUNT;
                            ID_MAPPING:  phase = PH_MCOUNT;
                            default: begin
                                if (len < HDR_LEN) begin
                                    queue_record(KIND_SHORT, 16'd0, len, {16'd0, id}, 32'd0);
                                end else if (len > HDR_LEN) begin
                                    skip_left = len - HDR_LEN;
                                    phase     = PH_SKIP;
                                end
                            end
                        endcase
                    end
                end
                PH_NAME: begin
                    queue_record(KIND_NAME, {11'd0, name_len}, {24'd0, b}, 32'd0, 32'd0);
                    name_len = name_len + 5'd1;
                    if (b == 8'd0 || name_len >= NAME_LIMIT) begin
                        name_len = '0;
                        clear_record();
                        phase    = PH_HEADER;
                    end
                end
                PH_VCOUNT, PH_FCOUNT, PH_MCOUNT: begin
                    place_byte(b, 4);
                    bcnt += 1;
                    if (bcnt >= 2) begin
                        // The mapping count opens its list without a record.
                        if (phase == PH_VCOUNT) begin
                            queue_record(KIND_VCOUNT, 16'd0, {16'd0, acc[0][15:0]}, 32'd0, 32'd0);
                            open_list(PH_VERTEX);
                        end else if (phase == PH_FCOUNT) begin
                            queue_record(KIND_FCOUNT, 16'd0, {16'd0, acc[0][15:0]}, 32'd0, 32'd0);
                            open_list(PH_FACE);
                        end else begin
                            open_list(PH_MAP);
                        end
                    end
                end
                PH_VERTEX: begin
                    place_byte(b, 4);
                    bcnt += 1;
                    if (bcnt >= 12) begin
                        queue_record(KIND_VERTEX, lpos, acc[0], acc[1], acc[2]);
                        next_record();
                    end
                end
                PH_FACE: begin
                    // The flag word in bytes six and seven is dropped.
                    if (bcnt < 6) place_byte(b, 2);
                    bcnt += 1;
                    if (bcnt >= 8) begin
                        queue_record(KIND_FACE, lpos, acc[0], acc[1], acc[2]);
                        next_record();
                    end
                end
                PH_MAP: begin
                    place_byte(b, 4);
                    bcnt += 1;
                    if (bcnt >= 8) begin
                        queue_record(KIND_MAP, lpos, acc[0], acc[1], 32'd0);
                        next_record();
                    end
                end
                PH_SKIP: begin
                    if (skip_left > 0) skip_left = skip_left - 32'd1;
                    if (skip_left == 0) phase = PH_HEADER;
                end
                default: begin
                    phase = PH_HEADER;
                    clear_record();
                end
            endcase
        endfunction

        function void check_field(string label, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            end
        endfunction

        function void check_record(t_out_item got);
            t_out_item want;
            if (pending_records.size() == 0) begin
                errors++;
                $display("%0t: record with none expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_records.pop_front();
            check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
            check_field("item_index", 32'(want.item_index), 32'(got.item_index));
            check_field("word_a", want.word_a, got.word_a);
            check_field("word_b", want.word_b, got.word_b);
            check_field("word_c", want.word_c, got.word_c);
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    chunk_record_scoreboard sb = new();
    t_in_item byte_stream[$];
    bit       resync_pending = 1'b1;
    bit       push_idle_on = 1'b1;
    bit       pop_idle_on = 1'b1;
    int       cycle_count = 0;

    mesh_chunk_stream_parser uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // All handshake signals are sampled at the edge, so the values seen here
    // are the ones from before the edge, whatever the order of processes.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) sb.note_byte(i_item);
        if (i_rst_n && pop && !empty) sb.check_record(o_result);
    end

    // Watchdog. A hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_mesh_chunk_stream_parser failed");
            $finish;
        end
    end

    function automatic void stream_byte(logic [7:0] b, logic start);
        t_in_item it;
        it.data_byte = b;
        it.file_start = start;
        byte_stream.push_back(it);
    endfunction

    function automatic void stream_u16(logic [15:0] v);
        stream_byte(v[7:0], 1'b0);
        stream_byte(v[15:8], 1'b0);
    endfunction

    // A header raises file_start after broken input, and now and then
    // without need. A restart on a header boundary must change nothing.
    function automatic void stream_header(logic [15:0] id, logic [31:0] len);
        logic start;
        start = resync_pending | ($urandom_range(0, 19) == 0);
        resync_pending = 1'b0;
        stream_byte(id[7:0], start);
        stream_byte(id[15:8], 1'b0);
        stream_u16(len[15:0]);
        stream_u16(len[31:16]);
    endfunction

    function automatic void stream_random_bytes(int n);
        repeat (n) stream_byte(8'($urandom), 1'b0);
    endfunction

    // Adds one chunk to the stream. Most chunks are well formed with random
    // content. The rest are cut-off lists, huge skips and plain noise, each
    // followed by a restart so that parsing gets back in step.
    function automatic void stream_random_chunk();
        int          pick;
        int          n;
        logic [15:0] id;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 2))
                0: id = ID_MAIN;
                1: id = ID_EDIT;
                default: id = ID_TRIMESH;
            endcase
            stream_header(id, $urandom);
        end else if (pick < 25) begin
            stream_header(ID_OBJECT, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                // Name that runs into the length limit without a zero.
                repeat (NAME_LIMIT) stream_byte(8'($urandom_range(1, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(0, NAME_LIMIT - 1))
                    stream_byte(8'($urandom_range(1, 255)), 1'b0);
                stream_byte(8'd0, 1'b0);
            end
        end else if (pick < 40) begin
            n = $urandom_range(0, 3);
            stream_header(ID_VERTICES, $urandom);
            stream_u16(16'(n));
            stream_random_bytes(n * 12);
        end else if (pick < 55) begin
            n = $urandom_range(0, 3);
            stream_header(ID_FACES, $urandom);
            stream_u16(16'(n));
            stream_random_bytes(n * 8);
        end else if (pick < 68) begin
            n = $urandom_range(0, 3);
            stream_header(ID_MAPPING, $urandom);
            stream_u16(16'(n));
            stream_random_bytes(n * 8);
        end else if (pick < 85) begin
            do id = 16'($urandom);
            while (id inside {ID_MAIN, ID_EDIT, ID_OBJECT, ID_TRIMESH,
                              ID_VERTICES, ID_FACES, ID_MAPPING});
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 5);
                1: len = HDR_LEN;
                default: len = $urandom_range(7, 30);
            endcase
            stream_header(id, len);
            if (len > HDR_LEN) stream_random_bytes(int'(len - HDR_LEN));
        end else if (pick < 93) begin
            if ($urandom_range(0, 1) == 0) begin
                // List with a random 16-bit count, cut off by a restart.
                case ($urandom_range(0, 2))
                    0: id = ID_VERTICES;
                    1: id = ID_FACES;
                    default: id = ID_MAPPING;
                endcase
                stream_header(id, $urandom);
                stream_u16(16'($urandom));
            end else begin
                // Unknown chunk with a long body, cut off by a restart.
                stream_header(16'h7f00 | 16'($urandom_range(0, 255)), $urandom | 32'h1000);
            end
            stream_random_bytes($urandom_range(0, 20));
            resync_pending = 1'b1;
        end else begin
            repeat ($urandom_range(1, 10))
                stream_byte(8'($urandom), $urandom_range(0, 3) == 0);
            resync_pending = 1'b1;
        end
    endfunction

    // Offers one request and holds it until the parser takes it. The valid
    // stays high straight into the next request when no gap is drawn.
    task automatic send_request(t_in_item it);
        int gap;
        if ($urandom_range(0, 39) == 0) push_idle_on = ($urandom_range(0, 2) != 0);
        gap = push_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk);
        while (full);
    endtask

    // The result side pops with its own random stalls, and now and then
    // runs stretches with none.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) pop_idle_on = ($urandom_range(0, 2) != 0);
            gap = pop_idle_on ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk);
            while (empty);
        end
    end

    initial begin
        int directed_bytes;

        // Directed part. An unknown chunk shorter than its own header gives
        // an error record. A vertex list with a zero count still reports the
        // count. A name that is only its zero byte ends at once. A header
        // abandoned after two bytes is cleared by the restart that follows.
        stream_header(16'h1234, 32'd3);
        stream_header(ID_VERTICES, 32'hffff_ffff);
        stream_u16(16'd0);
        stream_header(ID_OBJECT, 32'd7);
        stream_byte(8'd0, 1'b0);
        stream_byte(8'hff, 1'b0);
        stream_byte(8'h00, 1'b0);
        resync_pending = 1'b1;
        directed_bytes = byte_stream.size();

        while (byte_stream.size() < directed_bytes + RANDOM_BYTES) stream_random_chunk();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (byte_stream[i]) send_request(byte_stream[i]);
        push <= 1'b0;

        while (sb.pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_records.size() == 0) begin
            $display("tb_mesh_chunk_stream_parser passed");
        end else begin
            $display("tb_mesh_chunk_stream_parser failed");
        end
        $finish;
    end

endmodule
